/* rtl/core/rbvi_pkg.sv */
// Shared types and constants for the rigid body velocity integrator.
`timescale 1ns / 1ps
`default_nettype none

package rbvi_pkg;

    localparam int NUM_AXES = 3;
    localparam int AXIS_Y   = 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ACCEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_COEF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_CEILING    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_FLOOR      = 3'd6;

    localparam logic [23:0] INV_MASS_RESET = 24'h010000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAV_MUL,
        ST_GRAV_ADD,
        ST_FRIC_MUL,
        ST_FORCE_SUB,
        ST_ACC_MUL,
        ST_DT_MUL,
        ST_VEL_ADD,
        ST_LIMIT,
        ST_POS_MUL,
        ST_POS_ADD,
        ST_DAMP_MUL,
        ST_DAMP,
        ST_DONE
    } step_t;

    typedef struct packed {
        step_t step;
        logic  load;
    } seq_t;

    typedef struct packed {
        step_t step;
        logic  load;
        logic  body;
        logic  grav;
        logic  damp;
    } lane_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/rbvi_lane.sv */
// One axis lane: operand registers, a shared multiplier and the per-step update logic.
`timescale 1ns / 1ps
`default_nettype none

module rbvi_lane (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rbvi_pkg::lane_cmd_t cmd,
    input  wire logic signed [31:0]  force_in,
    input  wire logic signed [31:0]  pos_in,
    input  wire logic [15:0]         dt_in,
    input  wire logic [31:0]         gravity_accel,
    input  wire logic [15:0]         friction_coef,
    input  wire logic [23:0]         inv_mass,
    input  wire logic [15:0]         ceil_lim,
    input  wire logic [15:0]         floor_lim,
    output logic signed [31:0]       vel,
    output logic signed [31:0]       new_pos
);

    localparam int SUM_W  = 42;
    localparam int OPA_W  = 41;
    localparam int OPB_W  = 25;
    localparam int PROD_W = OPA_W + OPB_W;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (x < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return v[31] ? 33'(-w) : 33'(w);
    endfunction

    logic signed [31:0]       v_reg;
    logic signed [31:0]       f_reg;
    logic signed [31:0]       pos_reg;
    logic [15:0]              dt_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       np_reg;

    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] p_sh;

    logic [32:0]        ceil_mag;
    logic [32:0]        floor_mag;
    logic signed [31:0] ceil_pos;
    logic signed [31:0] ceil_neg;

    logic signed [31:0] grav_v;
    logic signed [31:0] grav_cl;
    logic signed [31:0] fsub_v;
    logic signed [31:0] vadd_v;
    logic [32:0]        v_mag;
    logic               over;
    logic signed [31:0] cl_v;
    logic [32:0]        cl_mag;
    logic signed [31:0] lim_v;
    logic signed [31:0] damped;
    logic signed [31:0] damp_v;
    logic signed [SUM_W-1:0] pos_sum;

    // Dropping 16 fraction bits rounds toward minus infinity, as an arithmetic shift does.
    assign p_sh = prod_reg >>> 16;

    assign ceil_mag  = {9'b0, ceil_lim, 8'b0};
    assign floor_mag = {9'b0, floor_lim, 8'b0};
    assign ceil_pos  = $signed({8'b0, ceil_lim, 8'b0});
    assign ceil_neg  = -ceil_pos;

    always_comb begin
        case (cmd.step)
            rbvi_pkg::ST_GRAV_MUL: begin
                op_a = $signed({9'b0, gravity_accel});
                op_b = $signed({9'b0, dt_reg});
            end
            rbvi_pkg::ST_FRIC_MUL, rbvi_pkg::ST_DAMP_MUL: begin
                op_a = OPA_W'(v_reg);
                op_b = $signed({9'b0, friction_coef});
            end
            rbvi_pkg::ST_ACC_MUL: begin
                op_a = OPA_W'(f_reg);
                op_b = $signed({1'b0, inv_mass});
            end
            rbvi_pkg::ST_DT_MUL: begin
                op_a = $signed(p_sh[OPA_W-1:0]);
                op_b = $signed({9'b0, dt_reg});
            end
            default: begin
                op_a = OPA_W'(v_reg);
                op_b = $signed({9'b0, dt_reg});
            end
        endcase
    end

    always_comb begin
        grav_v  = sat32(SUM_W'(v_reg) - SUM_W'($signed({1'b0, p_sh[32:0]})));
        grav_cl = (mag33(grav_v) > ceil_mag) ? (grav_v[31] ? ceil_neg : ceil_pos) : grav_v;

        fsub_v = sat32(SUM_W'(f_reg) - SUM_W'($signed(p_sh[32:0])));
        vadd_v = sat32(SUM_W'(v_reg) + $signed(p_sh[SUM_W-1:0]));

        v_mag  = mag33(v_reg);
        over   = v_mag > ceil_mag;
        cl_v   = over ? (v_reg[31] ? ceil_neg : ceil_pos) : v_reg;
        cl_mag = over ? ceil_mag : v_mag;
        lim_v  = (cl_mag < floor_mag) ? '0 : cl_v;

        damped = cmd.damp ? $signed(p_sh[31:0]) : v_reg;
        damp_v = (mag33(damped) < floor_mag) ? '0 : damped;

        if (cmd.body) begin
            pos_sum = SUM_W'(pos_reg) + $signed(p_sh[SUM_W-1:0]);
        end else begin
            pos_sum = SUM_W'(pos_reg) + SUM_W'(v_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            case (cmd.step)
                rbvi_pkg::ST_GRAV_ADD: begin
                    if (cmd.grav) begin
                        v_reg <= grav_cl;
                    end
                end
                rbvi_pkg::ST_VEL_ADD: v_reg <= vadd_v;
                rbvi_pkg::ST_LIMIT:   v_reg <= lim_v;
                rbvi_pkg::ST_DAMP:    v_reg <= damp_v;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        if (cmd.load) begin
            f_reg   <= force_in;
            pos_reg <= pos_in;
            dt_reg  <= dt_in;
        end else if (cmd.step == rbvi_pkg::ST_FORCE_SUB) begin
            f_reg <= fsub_v;
        end
        if (cmd.step == rbvi_pkg::ST_POS_ADD) begin
            np_reg <= sat32(pos_sum);
        end
    end

    assign vel     = v_reg;
    assign new_pos = np_reg;

endmodule

`default_nettype wire

/* rtl/core/rbvi_ctrl.sv */
// Step sequencer that drives all three axis lanes in lockstep.
`timescale 1ns / 1ps
`default_nettype none

module rbvi_ctrl (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      body_mode,
    input  wire logic      grav_en,
    input  wire logic      out_free,
    output logic           s_ready,
    output logic           out_load,
    output rbvi_pkg::seq_t seq
);

    rbvi_pkg::step_t state_reg;
    rbvi_pkg::step_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbvi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        seq.step   = state_reg;
        seq.load   = 1'b0;
        case (state_reg)
            rbvi_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                seq.load = s_valid;
                if (s_valid) begin
                    if (!body_mode) begin
                        state_next = rbvi_pkg::ST_ACC_MUL;
                    end else if (grav_en) begin
                        state_next = rbvi_pkg::ST_GRAV_MUL;
                    end else begin
                        state_next = rbvi_pkg::ST_FRIC_MUL;
                    end
                end
            end
            rbvi_pkg::ST_GRAV_MUL:  state_next = rbvi_pkg::ST_GRAV_ADD;
            rbvi_pkg::ST_GRAV_ADD:  state_next = rbvi_pkg::ST_FRIC_MUL;
            rbvi_pkg::ST_FRIC_MUL:  state_next = rbvi_pkg::ST_FORCE_SUB;
            rbvi_pkg::ST_FORCE_SUB: state_next = rbvi_pkg::ST_ACC_MUL;
            rbvi_pkg::ST_ACC_MUL:   state_next = rbvi_pkg::ST_DT_MUL;
            rbvi_pkg::ST_DT_MUL:    state_next = rbvi_pkg::ST_VEL_ADD;
            rbvi_pkg::ST_VEL_ADD: begin
                state_next = body_mode ? rbvi_pkg::ST_LIMIT : rbvi_pkg::ST_DAMP_MUL;
            end
            rbvi_pkg::ST_LIMIT:     state_next = rbvi_pkg::ST_POS_MUL;
            rbvi_pkg::ST_POS_MUL:   state_next = rbvi_pkg::ST_POS_ADD;
            rbvi_pkg::ST_DAMP_MUL:  state_next = rbvi_pkg::ST_DAMP;
            rbvi_pkg::ST_DAMP:      state_next = rbvi_pkg::ST_POS_ADD;
            rbvi_pkg::ST_POS_ADD:   state_next = rbvi_pkg::ST_DONE;
            rbvi_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = rbvi_pkg::ST_IDLE;
                end
            end
            default: state_next = rbvi_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/rigid_body_velocity_integrator.sv */
// Top level of the rigid body velocity integrator: configuration, lanes and result register.
`timescale 1ns / 1ps
`default_nettype none

// Semi-implicit Euler step for one body in Q16.16 fixed point. Each input transaction carries
// a force, a time step and a position; the block updates its kept velocity and returns one
// result transaction with the new position and velocity. Three axis lanes run side by side,
// each walking through a chain of dependent multiplies on its own 41x25 multiplier. The next
// transaction is accepted only once the result has been loaded into the output register.
// A finished result waits in the output register while the next transaction is accepted.
// Configuration writes take effect at once and must only be issued while no transaction is
// in flight.
module rigid_body_velocity_integrator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rbvi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rbvi_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [31:0]                s_force_x,
    input  wire logic signed [31:0]                s_force_y,
    input  wire logic signed [31:0]                s_force_z,
    input  wire logic [15:0]                       s_step_time,
    input  wire logic signed [31:0]                s_pos_x,
    input  wire logic signed [31:0]                s_pos_y,
    input  wire logic signed [31:0]                s_pos_z,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [31:0]                     m_new_pos_x,
    output logic signed [31:0]                     m_new_pos_y,
    output logic signed [31:0]                     m_new_pos_z,
    output logic signed [31:0]                     m_vel_x,
    output logic signed [31:0]                     m_vel_y,
    output logic signed [31:0]                     m_vel_z
);

    localparam int N = rbvi_pkg::NUM_AXES;

    logic        step_mode_reg;
    logic        gravity_enable_reg;
    logic [31:0] gravity_accel_reg;
    logic [15:0] friction_coef_reg;
    logic [23:0] inv_mass_reg;
    logic [47:0] vel_ceiling_reg;
    logic [47:0] vel_floor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_mode_reg      <= 1'b0;
            gravity_enable_reg <= 1'b0;
            gravity_accel_reg  <= '0;
            friction_coef_reg  <= '0;
            inv_mass_reg       <= rbvi_pkg::INV_MASS_RESET;
            vel_ceiling_reg    <= '1;
            vel_floor_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rbvi_pkg::CFG_STEP_MODE:      step_mode_reg      <= cfg_wr_data[0];
                rbvi_pkg::CFG_GRAVITY_ENABLE: gravity_enable_reg <= cfg_wr_data[0];
                rbvi_pkg::CFG_GRAVITY_ACCEL:  gravity_accel_reg  <= cfg_wr_data[31:0];
                rbvi_pkg::CFG_FRICTION_COEF:  friction_coef_reg  <= cfg_wr_data[15:0];
                rbvi_pkg::CFG_INV_MASS:       inv_mass_reg       <= cfg_wr_data[23:0];
                rbvi_pkg::CFG_VEL_CEILING:    vel_ceiling_reg    <= cfg_wr_data[47:0];
                rbvi_pkg::CFG_VEL_FLOOR:      vel_floor_reg      <= cfg_wr_data[47:0];
                default: ;
            endcase
        end
    end

    logic           out_load;
    logic           out_free;
    logic           m_valid_reg;
    rbvi_pkg::seq_t seq;

    assign out_free = !m_valid_reg || m_ready;

    rbvi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .body_mode (!step_mode_reg),
        .grav_en   (gravity_enable_reg),
        .out_free  (out_free),
        .s_ready   (s_ready),
        .out_load  (out_load),
        .seq       (seq)
    );

    logic signed [31:0] force_arr [N];
    logic signed [31:0] pos_arr   [N];
    logic signed [31:0] vel_arr   [N];
    logic signed [31:0] np_arr    [N];

    assign force_arr[0] = s_force_x;
    assign force_arr[1] = s_force_y;
    assign force_arr[2] = s_force_z;
    assign pos_arr[0]   = s_pos_x;
    assign pos_arr[1]   = s_pos_y;
    assign pos_arr[2]   = s_pos_z;

    for (genvar i = 0; i < N; i++) begin : g_lane
        localparam logic IS_Y = (i == rbvi_pkg::AXIS_Y);
        rbvi_pkg::lane_cmd_t cmd;

        assign cmd.step = seq.step;
        assign cmd.load = seq.load;
        assign cmd.body = !step_mode_reg;
        assign cmd.grav = IS_Y && gravity_enable_reg;
        assign cmd.damp = !(IS_Y && gravity_enable_reg);

        rbvi_lane u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd           (cmd),
            .force_in      (force_arr[i]),
            .pos_in        (pos_arr[i]),
            .dt_in         (s_step_time),
            .gravity_accel (gravity_accel_reg),
            .friction_coef (friction_coef_reg),
            .inv_mass      (inv_mass_reg),
            .ceil_lim      (vel_ceiling_reg[16*i +: 16]),
            .floor_lim     (vel_floor_reg[16*i +: 16]),
            .vel           (vel_arr[i]),
            .new_pos       (np_arr[i])
        );
    end

    logic signed [31:0] new_pos_out_reg [N];
    logic signed [31:0] vel_out_reg     [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            new_pos_out_reg <= np_arr;
            vel_out_reg     <= vel_arr;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_pos_x = new_pos_out_reg[0];
    assign m_new_pos_y = new_pos_out_reg[1];
    assign m_new_pos_z = new_pos_out_reg[2];
    assign m_vel_x     = vel_out_reg[0];
    assign m_vel_y     = vel_out_reg[1];
    assign m_vel_z     = vel_out_reg[2];

`ifndef SYNTHESIS
    // A new transaction is never taken in the cycle right after one was accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while the previous transaction is still in the lanes");

    // A result is only loaded when the output register is free or being drained.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    // A loaded result always shows up as valid on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("loaded result not presented");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
